/* rtl/core/mwr_pkg.sv */
package mwr_pkg;

	// command codes of an input item
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// exchange status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FAIL    = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

	// configuration register indexes
	localparam logic [7:0] REG_SLAVE_ADDRESS    = 8'd0;
	localparam logic [7:0] REG_REGISTER_ADDRESS = 8'd1;
	localparam logic [7:0] REG_REGISTER_VALUE   = 8'd2;
	localparam logic [7:0] REG_TIMEOUT_TICKS    = 8'd3;

	// frame constants
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam int          FRAME_BYTES       = 8;
	localparam int          HEADER_BYTES      = FRAME_BYTES - 2;
	localparam int          IDX_W             = $clog2(FRAME_BYTES);

	// job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// configuration register set
	typedef struct packed {
		logic [7:0]  slave_address;
		logic [15:0] register_address;
		logic [15:0] register_value;
		logic [31:0] timeout_ticks;
	} cfg_t;

	// one job: send a frame, or report a finished exchange
	typedef struct packed {
		logic       send;
		logic [1:0] status;
	} job_t;

	// crc-16/modbus update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// header byte i of the request, from the registers
	function automatic logic [7:0] header_byte(input cfg_t cfg, input logic [IDX_W-1:0] i);
		logic [7:0] b;
		unique case (i)
			3'd0: b = cfg.slave_address;
			3'd1: b = FUNC_WRITE_SINGLE;
			3'd2: b = cfg.register_address[15:8];
			3'd3: b = cfg.register_address[7:0];
			3'd4: b = cfg.register_value[15:8];
			default: b = cfg.register_value[7:0];
		endcase
		return b;
	endfunction

endpackage

/* rtl/core/mwr_front.sv */
module mwr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  mwr_pkg::cfg_t  cfg,
	input  logic           in_accept,
	input  logic [1:0]     command,
	input  logic [7:0]     rx_byte,
	output logic           job_push,
	output mwr_pkg::job_t  job_data
);
	import mwr_pkg::*;

	logic             waiting_q;
	logic [IDX_W-1:0] rcount_q;
	logic [15:0]      rcrc_q;
	logic             echo_q;
	logic [7:0]       crc_lo_q;
	logic [31:0]      ticks_q;

	logic [31:0] ticks_next;
	logic        frame_end;
	logic        timed_out;
	logic        resp_ok;

	// saturating tick count and end-of-exchange checks
	assign ticks_next = (ticks_q == 32'hFFFF_FFFF) ? ticks_q : ticks_q + 32'd1;
	assign timed_out  = (ticks_next >= cfg.timeout_ticks);
	assign frame_end  = (rcount_q == IDX_W'(FRAME_BYTES - 1));
	assign resp_ok    = echo_q && ({rx_byte, crc_lo_q} == rcrc_q);

	// job generation
	always_comb begin
		job_push = 1'b0;
		job_data = '0;
		if (in_accept) begin
			if (command == CMD_START) begin
				job_push      = 1'b1;
				job_data.send = 1'b1;
			end else if (waiting_q && command == CMD_BYTE && frame_end) begin
				job_push        = 1'b1;
				job_data.status = resp_ok ? STATUS_OK : STATUS_FAIL;
			end else if (waiting_q && command == CMD_TICK && timed_out) begin
				job_push        = 1'b1;
				job_data.status = STATUS_TIMEOUT;
			end
		end
	end

	// receive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			rcount_q  <= '0;
			rcrc_q    <= CRC_INIT;
			echo_q    <= 1'b1;
			crc_lo_q  <= '0;
			ticks_q   <= '0;
		end else if (in_accept) begin
			if (command == CMD_START) begin
				waiting_q <= 1'b1;
				rcount_q  <= '0;
				rcrc_q    <= CRC_INIT;
				echo_q    <= 1'b1;
				crc_lo_q  <= '0;
				ticks_q   <= '0;
			end else if (waiting_q && command == CMD_BYTE) begin
				if (rcount_q < IDX_W'(HEADER_BYTES)) begin
					rcrc_q   <= crc_byte(rcrc_q, rx_byte);
					if (rx_byte != header_byte(cfg, rcount_q)) begin
						echo_q <= 1'b0;
					end
					rcount_q <= rcount_q + 1'b1;
				end else if (!frame_end) begin
					crc_lo_q <= rx_byte;
					rcount_q <= rcount_q + 1'b1;
				end else begin
					waiting_q <= 1'b0;
					rcount_q  <= '0;
					rcrc_q    <= CRC_INIT;
					echo_q    <= 1'b1;
					crc_lo_q  <= '0;
					ticks_q   <= '0;
				end
			end else if (waiting_q && command == CMD_TICK) begin
				if (timed_out) begin
					waiting_q <= 1'b0;
					rcount_q  <= '0;
					rcrc_q    <= CRC_INIT;
					echo_q    <= 1'b1;
					crc_lo_q  <= '0;
					ticks_q   <= '0;
				end else begin
					ticks_q <= ticks_next;
				end
			end
		end
	end

endmodule

/* rtl/core/mwr_job_fifo.sv */
module mwr_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mwr_pkg::job_t  push_data,
	output logic           full,
	input  logic           pop,
	output mwr_pkg::job_t  pop_data,
	output logic           empty
);
	import mwr_pkg::*;

	job_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slots_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/mwr_back.sv */
module mwr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mwr_pkg::cfg_t  cfg,
	input  logic           job_empty,
	input  mwr_pkg::job_t  job,
	output logic           job_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     tx_byte,
	output logic           tx_valid,
	output logic           tx_last,
	output logic           done_res,
	output logic [1:0]     status
);
	import mwr_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       tx_byte_q;
	logic             tx_valid_q;
	logic             tx_last_q;
	logic             done_q;
	logic [1:0]       status_q;

	logic        out_free;
	logic        step;
	logic [7:0]  hdr;
	logic [15:0] crc_base;
	logic [7:0]  frame_byte;
	logic        frame_last;

	assign out_free   = !out_valid_q || pop;
	assign step       = !job_empty && out_free;
	assign hdr        = header_byte(cfg, idx_q);
	assign crc_base   = (idx_q == '0) ? CRC_INIT : crc_q;
	assign frame_last = (idx_q == IDX_W'(FRAME_BYTES - 1));

	// byte of the frame at the current position
	always_comb begin
		if (idx_q < IDX_W'(HEADER_BYTES)) begin
			frame_byte = hdr;
		end else if (!frame_last) begin
			frame_byte = crc_q[7:0];
		end else begin
			frame_byte = crc_q[15:8];
		end
	end

	assign job_pop = step && (!job.send || frame_last);

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (step && job.send) begin
			if (idx_q < IDX_W'(HEADER_BYTES)) begin
				crc_q <= crc_byte(crc_base, hdr);
			end
			idx_q <= frame_last ? '0 : idx_q + 1'b1;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			if (job.send) begin
				tx_byte_q  <= frame_byte;
				tx_valid_q <= 1'b1;
				tx_last_q  <= frame_last;
				done_q     <= 1'b0;
				status_q   <= STATUS_OK;
			end else begin
				tx_byte_q  <= 8'h00;
				tx_valid_q <= 1'b0;
				tx_last_q  <= 1'b0;
				done_q     <= 1'b1;
				status_q   <= job.status;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign tx_byte  = tx_byte_q;
	assign tx_valid = tx_valid_q;
	assign tx_last  = tx_last_q;
	assign done_res = done_q;
	assign status   = status_q;

endmodule

/* rtl/core/modbus_write_register_master_unit.sv */
// flow: a queued start sends its frame bytes to the result register one a cycle while free
// a finishing byte or a timeout tick queues a job that loads its done result there
// throughput: one input item per cycle while full is low; results leave one per cycle
// while popped; the byte sequencer sends 8-byte frames, and a 4-entry job queue absorbs bursts
// reset: arst_n asynchronous active low; registers return to slave 1, register 4,
// value 3, timeout 2, and the master goes idle with the queue and result register empty
module modbus_write_register_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic        tx_last,
	output logic        done_res,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mwr_pkg::*;

	cfg_t cfg_q;
	logic in_accept;
	logic job_push;
	job_t job_in;
	job_t job_out;
	logic job_empty;
	logic job_pop;

	assign cfg_ready = 1'b1;
	assign in_accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address    <= 8'd1;
			cfg_q.register_address <= 16'd4;
			cfg_q.register_value   <= 16'd3;
			cfg_q.timeout_ticks    <= 32'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SLAVE_ADDRESS:    cfg_q.slave_address    <= cfg_data[7:0];
				REG_REGISTER_ADDRESS: cfg_q.register_address <= cfg_data[15:0];
				REG_REGISTER_VALUE:   cfg_q.register_value   <= cfg_data[15:0];
				REG_TIMEOUT_TICKS:    cfg_q.timeout_ticks    <= cfg_data;
				default: ;
			endcase
		end
	end

	mwr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_accept (in_accept),
		.command   (command),
		.rx_byte   (rx_byte),
		.job_push  (job_push),
		.job_data  (job_in)
	);

	mwr_job_fifo u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.empty     (job_empty)
	);

	mwr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.tx_byte   (tx_byte),
		.tx_valid  (tx_valid),
		.tx_last   (tx_last),
		.done_res  (done_res),
		.status    (status)
	);

endmodule
